[src/lsbse_pkg.sv]
// Shared types, register indexes and defaults for the LSB steganography block.
// No dependencies; the embed/extract module and the checker import this package.
package lsbse_pkg;

    localparam int POSITION_BITS_DEFAULT = 24;
    localparam int CFG_DATA_BITS         = 16;
    localparam int CFG_INDEX_BITS        = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_EXTRACT_MODE  = 2'd0,
        CFG_HEADER_LENGTH = 2'd1,
        CFG_SLOT_STRIDE   = 2'd2
    } cfg_index_t;

    localparam logic        EXTRACT_MODE_RESET  = 1'b0;
    localparam logic [15:0] HEADER_LENGTH_RESET = 16'd54;
    localparam logic [3:0]  SLOT_STRIDE_RESET   = 4'd2;
    localparam logic [3:0]  SLOT_STRIDE_MAX     = 4'd8;
    localparam logic [2:0]  LAST_BIT_INDEX      = 3'd7;
    localparam logic [7:0]  TERMINATOR_CHAR     = 8'd0;

    typedef struct packed {
        logic [7:0] carrier_byte;
        logic [7:0] message_char;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       char_taken;
        logic [7:0] decoded_char;
        logic       char_valid;
        logic       finished;
    } result_t;

endpackage

[src/lsbse_stream_if.sv]
// Valid/ready stream channel carrying one payload per transaction.
// Payload type is a parameter; the block uses item_t and result_t from lsbse_pkg.
interface lsbse_stream_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/lsb_stego_embed_extract.sv]
// LSB steganography embedder and extractor, one image byte per transaction.
// Depends on lsbse_pkg and lsbse_stream_if.
// The result of an input transaction is held in the output register from the next cycle.
// Throughput: one byte per cycle; the input is ready whenever the output register
// is empty or being drained in the same cycle.
// Reset (rst_n low, asynchronous): registers return to extract_mode 0, header 54,
// stride 2, all stream counters cleared and the output register empty.
module lsb_stego_embed_extract
    import lsbse_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    lsbse_stream_if.sink              item,
    lsbse_stream_if.source            result,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // Configuration registers
    logic        extract_mode_reg;
    logic [15:0] header_length_reg;
    logic [3:0]  slot_stride_reg;

    // Stream state
    logic [POSITION_BITS-1:0] byte_position_reg, byte_position_next;
    logic [2:0]               stride_phase_reg, stride_phase_next;
    logic [2:0]               bit_count_reg, bit_count_next;
    logic [7:0]               char_shift_reg, char_shift_next;
    logic                     done_flag_reg, done_flag_next;

    // Output register
    logic    out_valid_reg;
    result_t out_payload_reg, out_payload_next;

    item_t                    in_item;
    logic                     accept;
    logic [2:0]               stride_m1;
    logic                     past_header;
    logic                     slot;
    logic                     active_slot;
    logic [7:0]               cur_char;
    logic [7:0]               gathered;
    logic [POSITION_BITS-1:0] header_ext;

    assign in_item     = item.payload;
    // Take a new byte whenever the output register is empty or drains this cycle.
    assign item.ready  = !out_valid_reg || result.ready;
    assign accept      = item.valid && item.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_payload_reg;

    // Configuration writes; an unused index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extract_mode_reg  <= EXTRACT_MODE_RESET;
            header_length_reg <= HEADER_LENGTH_RESET;
            slot_stride_reg   <= SLOT_STRIDE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_EXTRACT_MODE:  extract_mode_reg  <= cfg_data[0];
                CFG_HEADER_LENGTH: header_length_reg <= cfg_data[15:0];
                CFG_SLOT_STRIDE:   slot_stride_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Clamp the stride into 1..8 and keep it as stride minus one, which fits 3 bits.
    always_comb
    begin
        if (slot_stride_reg == 4'd0)
            stride_m1 = 3'd0;
        else if (slot_stride_reg > SLOT_STRIDE_MAX)
            stride_m1 = LAST_BIT_INDEX;
        else
            stride_m1 = 3'(slot_stride_reg - 4'd1);
    end

    assign header_ext  = POSITION_BITS'(header_length_reg);
    assign past_header = byte_position_reg > header_ext;
    assign slot        = past_header && (stride_phase_reg >= stride_m1);
    assign active_slot = slot && !done_flag_reg;

    // Embed latches the host character on the first bit of each character.
    assign cur_char = (bit_count_reg == 3'd0) ? in_item.message_char : char_shift_reg;
    // Extract starts a fresh character on the first bit and ORs in the slot LSB.
    assign gathered = ((bit_count_reg == 3'd0) ? 8'd0 : char_shift_reg)
                    | (8'(in_item.carrier_byte[0]) << bit_count_reg);

    // Per-byte update of the stream state and the result fields.
    always_comb
    begin
        byte_position_next = byte_position_reg;
        stride_phase_next  = stride_phase_reg;
        bit_count_next     = bit_count_reg;
        char_shift_next    = char_shift_reg;
        done_flag_next     = done_flag_reg;

        out_payload_next              = '0;
        out_payload_next.out_byte     = in_item.carrier_byte;

        // Advance the slot phase only once the header is behind us.
        if (past_header)
        begin
            if (slot)
                stride_phase_next = 3'd0;
            else
                stride_phase_next = stride_phase_reg + 3'd1;
        end

        // Saturate the byte position.
        if (byte_position_reg != {POSITION_BITS{1'b1}})
            byte_position_next = byte_position_reg + POSITION_BITS'(1);

        if (active_slot)
        begin
            if (!extract_mode_reg)
            begin
                char_shift_next             = cur_char;
                out_payload_next.char_taken = (bit_count_reg == 3'd0);
                out_payload_next.out_byte   = {in_item.carrier_byte[7:1],
                                               cur_char[bit_count_reg]};
            end
            else
            begin
                char_shift_next = gathered;
            end

            if (bit_count_reg == LAST_BIT_INDEX)
            begin
                if (extract_mode_reg)
                begin
                    out_payload_next.decoded_char = char_shift_next;
                    out_payload_next.char_valid   = 1'b1;
                end
                // Stop once the terminator has gone through all eight slots.
                if (char_shift_next == TERMINATOR_CHAR)
                    done_flag_next = 1'b1;
                bit_count_next = 3'd0;
            end
            else
            begin
                bit_count_next = bit_count_reg + 3'd1;
            end
        end

        out_payload_next.finished = done_flag_next;

        // Image end: drop any unfinished character and restart the stream.
        if (in_item.last_byte)
        begin
            byte_position_next = '0;
            stride_phase_next  = 3'd0;
            bit_count_next     = 3'd0;
            char_shift_next    = 8'd0;
            done_flag_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            stride_phase_reg  <= 3'd0;
            bit_count_reg     <= 3'd0;
            char_shift_reg    <= 8'd0;
            done_flag_reg     <= 1'b0;
        end
        else if (accept)
        begin
            byte_position_reg <= byte_position_next;
            stride_phase_reg  <= stride_phase_next;
            bit_count_reg     <= bit_count_next;
            char_shift_reg    <= char_shift_next;
            done_flag_reg     <= done_flag_next;
        end
    end

    // Output register: load on accept, drop the valid once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_payload_reg <= out_payload_next;
    end

endmodule

[src/lsbse_checker.sv]
// Port-level checks for lsb_stego_embed_extract, attached by the bind below.
// Depends on lsbse_pkg for the result payload type.
module lsbse_checker
    import lsbse_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_payload
);

    // A stalled result must hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_payload))
        else $error("stalled result changed");

    // A character is never latched and decoded on the same byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_payload.char_taken && result_payload.char_valid))
        else $error("char_taken and char_valid together");

    // Latching a character starts it, so the terminator cannot be done yet.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_payload.char_taken |-> !result_payload.finished)
        else $error("char_taken while finished");

    // A decoded character finishes the stream exactly when it is the terminator.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_payload.char_valid
        |-> result_payload.finished == (result_payload.decoded_char == TERMINATOR_CHAR))
        else $error("finished disagrees with decoded character");

endmodule

bind lsb_stego_embed_extract lsbse_checker u_lsbse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .result_valid   (result.valid),
    .result_ready   (result.ready),
    .result_payload (result.payload)
);
